// ===== src/ghm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghm_pkg
// Shared types and constants for the GHASH GF(2^128) multiply-accumulate block.
// ----------------------------------------------------------------------------
package ghm_pkg;

    // Lane and product widths.
    localparam int LANE_W  = 64;
    localparam int PROD_W  = 2 * LANE_W;

    // Operation codes carried in the kind field. Code 3 has no meaning.
    typedef enum logic [1:0] {
        KIND_ABSORB = 2'd0,
        KIND_RAW    = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_HI   = 2'd0;
    localparam logic [1:0] CFG_KEY_LO   = 2'd1;
    localparam logic [1:0] CFG_BYTE_REV = 2'd2;

    // One operand pair for the field multiplier.
    typedef struct packed {
        logic [LANE_W-1:0] a_hi;
        logic [LANE_W-1:0] a_lo;
        logic [LANE_W-1:0] b_hi;
        logic [LANE_W-1:0] b_lo;
    } gf_operands_t;

endpackage

// ===== src/ghm_clmul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghm_clmul64
// 64x64 carry-less multiplier giving a 128-bit product as an AND-XOR array.
// ----------------------------------------------------------------------------
module ghm_clmul64 (
    input  logic [63:0]  x,
    input  logic [63:0]  y,
    output logic [127:0] product
);
    import ghm_pkg::*;

    logic [PROD_W-1:0] prod;

    // Each product bit is the XOR of all partial-product bits of its weight.
    always_comb
    begin
        prod = '0;
        for (int i = 0; i < LANE_W; i++)
        begin
            for (int j = 0; j < LANE_W; j++)
            begin
                prod[i + j] = prod[i + j] ^ (x[i] & y[j]);
            end
        end
    end

    assign product = prod;

endmodule

// ===== src/ghm_gf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghm_gf_mul
// GF(2^128) multiplier in reflected bit order: four 64x64 carry-less products,
// a one-bit left shift of the 256-bit sum and a shift-and-XOR reduction.
// ----------------------------------------------------------------------------
module ghm_gf_mul (
    input  ghm_pkg::gf_operands_t ops,
    output logic [63:0]           r_hi,
    output logic [63:0]           r_lo
);
    import ghm_pkg::*;

    logic [PROD_W-1:0] p_ll;
    logic [PROD_W-1:0] p_hh;
    logic [PROD_W-1:0] p_lh;
    logic [PROD_W-1:0] p_hl;
    logic [LANE_W-1:0] mid_hi;
    logic [LANE_W-1:0] mid_lo;
    logic [LANE_W-1:0] x0, x1, x2, x3;
    logic [LANE_W-1:0] s0, s1, s2, s3;
    logic [LANE_W-1:0] dd, h1, h0;

    // Partial products of the schoolbook split.
    ghm_clmul64 u_clmul_ll (.x(ops.a_lo), .y(ops.b_lo), .product(p_ll));
    ghm_clmul64 u_clmul_hh (.x(ops.a_hi), .y(ops.b_hi), .product(p_hh));
    ghm_clmul64 u_clmul_lh (.x(ops.a_lo), .y(ops.b_hi), .product(p_lh));
    ghm_clmul64 u_clmul_hl (.x(ops.a_hi), .y(ops.b_lo), .product(p_hl));

    // Assemble the 256-bit product and shift it left by one.
    always_comb
    begin
        mid_hi = p_lh[PROD_W-1:LANE_W] ^ p_hl[PROD_W-1:LANE_W];
        mid_lo = p_lh[LANE_W-1:0] ^ p_hl[LANE_W-1:0];
        x0 = p_ll[LANE_W-1:0];
        x1 = p_ll[PROD_W-1:LANE_W] ^ mid_lo;
        x2 = p_hh[LANE_W-1:0] ^ mid_hi;
        x3 = p_hh[PROD_W-1:LANE_W];
        s0 = {x0[LANE_W-2:0], 1'b0};
        s1 = {x1[LANE_W-2:0], x0[LANE_W-1]};
        s2 = {x2[LANE_W-2:0], x1[LANE_W-1]};
        s3 = {x3[LANE_W-2:0], x2[LANE_W-1]};
    end

    // Reduce modulo x^128 + x^7 + x^2 + x + 1 in reflected order.
    always_comb
    begin
        dd = s1 ^ (s0 << 63) ^ (s0 << 62) ^ (s0 << 57);
        h1 = dd ^ (dd >> 1) ^ (dd >> 2) ^ (dd >> 7);
        h0 = s0 ^ (s0 >> 1) ^ (s0 >> 2) ^ (s0 >> 7)
             ^ (dd << 63) ^ (dd << 62) ^ (dd << 57);
        r_hi = s3 ^ h1;
        r_lo = s2 ^ h0;
    end

endmodule

// ===== src/ghash_gf128_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_gf128_multiply_accumulate
// GHASH engine: absorbs 128-bit blocks into an accumulator multiplied by H.
// ----------------------------------------------------------------------------
// Usage:
// Load the hash key through the write port (index 0 upper lane, index 1 lower
// lane, index 2 byte reversal enable) while the block is idle. Blocks enter
// on the block channel (block_valid / block_stall) with a kind: absorb, raw
// multiply by H, or clear. Every transaction returns one result on the result
// channel (result_valid / result_stall): the new accumulator, or the raw
// product. Code 3 returns the current accumulator unchanged.
// An item passes from the input register through the field multiplier
// into the result register, which also updates the accumulator. Throughput
// is one block per cycle unless the receiver stalls; the accumulator loop
// closes in a single multiplier pass, so back-to-back absorbs run at full rate.
// When the receiver stalls, the result register holds and the input register
// fills; block_stall rises once both are occupied.
// Reset clears the accumulator, both key lanes, both valid flags, and sets
// byte reversal on.
// ----------------------------------------------------------------------------
module ghash_gf128_multiply_accumulate (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Block channel.
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    // Result channel.
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);
    import ghm_pkg::*;

    // Reverses the bytes of one lane.
    function automatic logic [LANE_W-1:0] swap_bytes(input logic [LANE_W-1:0] v);
        logic [LANE_W-1:0] r;
        for (int i = 0; i < LANE_W / 8; i++)
        begin
            r[8*i +: 8] = v[LANE_W - 8 - 8*i +: 8];
        end
        return r;
    endfunction

    logic [LANE_W-1:0] key_hi_reg;
    logic [LANE_W-1:0] key_lo_reg;
    logic              byte_rev_reg;
    logic [LANE_W-1:0] acc_hi_reg;
    logic [LANE_W-1:0] acc_lo_reg;
    logic [LANE_W-1:0] acc_hi_next;
    logic [LANE_W-1:0] acc_lo_next;
    logic              in_valid_reg;
    kind_t             in_kind_reg;
    logic [LANE_W-1:0] in_hi_reg;
    logic [LANE_W-1:0] in_lo_reg;
    logic              result_valid_reg;
    logic [LANE_W-1:0] result_hi_reg;
    logic [LANE_W-1:0] result_lo_reg;
    logic [LANE_W-1:0] res_hi_next;
    logic [LANE_W-1:0] res_lo_next;
    logic              advance;
    logic              load_in;
    logic [LANE_W-1:0] data_hi;
    logic [LANE_W-1:0] data_lo;
    gf_operands_t      ops;
    logic [LANE_W-1:0] prod_hi;
    logic [LANE_W-1:0] prod_lo;

    // Pipeline flow control.
    assign advance     = !result_valid_reg || !result_stall;
    assign load_in     = !in_valid_reg || advance;
    assign block_stall = in_valid_reg && !advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            byte_rev_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_HI:   key_hi_reg   <= cfg_data;
                CFG_KEY_LO:   key_lo_reg   <= cfg_data;
                CFG_BYTE_REV: byte_rev_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_valid_reg <= block_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && block_valid)
        begin
            in_kind_reg <= kind_t'(kind);
            in_hi_reg   <= block_hi;
            in_lo_reg   <= block_lo;
        end
    end

    // Select the multiplier operands for the held item.
    always_comb
    begin
        if (byte_rev_reg)
        begin
            data_hi = swap_bytes(in_lo_reg);
            data_lo = swap_bytes(in_hi_reg);
        end
        else
        begin
            data_hi = in_hi_reg;
            data_lo = in_lo_reg;
        end
        ops.b_hi = key_hi_reg;
        ops.b_lo = key_lo_reg;
        if (in_kind_reg == KIND_RAW)
        begin
            ops.a_hi = in_hi_reg;
            ops.a_lo = in_lo_reg;
        end
        else
        begin
            ops.a_hi = acc_hi_reg ^ data_hi;
            ops.a_lo = acc_lo_reg ^ data_lo;
        end
    end

    ghm_gf_mul u_gf_mul (
        .ops  (ops),
        .r_hi (prod_hi),
        .r_lo (prod_lo)
    );

    // Result and accumulator update per kind.
    always_comb
    begin
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        res_hi_next = acc_hi_reg;
        res_lo_next = acc_lo_reg;
        unique case (in_kind_reg)
            KIND_ABSORB:
            begin
                acc_hi_next = prod_hi;
                acc_lo_next = prod_lo;
                res_hi_next = prod_hi;
                res_lo_next = prod_lo;
            end
            KIND_RAW:
            begin
                res_hi_next = prod_hi;
                res_lo_next = prod_lo;
            end
            KIND_CLEAR:
            begin
                acc_hi_next = '0;
                acc_lo_next = '0;
                res_hi_next = '0;
                res_lo_next = '0;
            end
            default:
            begin
                res_hi_next = acc_hi_reg;
                res_lo_next = acc_lo_reg;
            end
        endcase
    end

    // Accumulator and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hi_reg       <= '0;
            acc_lo_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                acc_hi_reg <= acc_hi_next;
                acc_lo_reg <= acc_lo_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_hi_reg <= res_hi_next;
            result_lo_reg <= res_lo_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_hi    = result_hi_reg;
    assign result_lo    = result_lo_reg;

    // The accumulator moves only when an item passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid_reg && advance) |=> $stable(acc_hi_reg) && $stable(acc_lo_reg))
        else $error("accumulator changed without a transaction");

    // A clear leaves a zero accumulator behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && in_kind_reg == KIND_CLEAR)
        |=> acc_hi_reg == '0 && acc_lo_reg == '0)
        else $error("accumulator not zero after clear");

    // An absorb reports the new accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && in_kind_reg == KIND_ABSORB)
        |=> result_hi_reg == acc_hi_reg && result_lo_reg == acc_lo_reg)
        else $error("absorb result differs from accumulator");

    // The block channel stalls only with a held item and a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        block_stall |-> in_valid_reg && result_valid_reg && result_stall)
        else $error("block channel stalled without back-pressure");

endmodule

// ===== tb/sv/ghash_gf128_multiply_accumulate_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_gf128_multiply_accumulate_check
// Watches the write port and both channels of the GHASH engine. It keeps its
// own copy of the hash key, the byte reversal enable and the accumulator,
// predicts the result of every accepted block, and compares each accepted
// result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ghash_gf128_multiply_accumulate_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        block_valid,
    input  logic        block_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [63:0] result_hi,
    input  logic [63:0] result_lo,
    output int          products_in_flight,
    output int          mismatch_count
);
    import ghm_pkg::*;

    // Shadow copy of the configuration and of the accumulator.
    logic [127:0] hash_key;
    logic         swap_enable;
    logic [127:0] acc_model;

    // Predicted results, oldest first.
    logic [127:0] pending_products[$];

    // Reverse the sixteen bytes of a block.
    function automatic logic [127:0] reverse_bytes(input logic [127:0] v);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[8*(15-i) +: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

    // Carry-less 128x128 product, shifted left by one and reduced modulo
    // x^128 + x^7 + x^2 + x + 1 in reflected bit order.
    function automatic logic [127:0] gf128_mul(input logic [127:0] a,
                                               input logic [127:0] b);
        logic [255:0] prod;
        logic [63:0]  s0, s1, s2, s3, dd, h0, h1;
        prod = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (b[i])
                prod = prod ^ ({128'b0, a} << i);
        end
        prod = prod << 1;
        {s3, s2, s1, s0} = prod;
        dd = s1 ^ (s0 << 63) ^ (s0 << 62) ^ (s0 << 57);
        h1 = dd ^ (dd >> 1) ^ (dd >> 2) ^ (dd >> 7);
        h0 = s0 ^ (s0 >> 1) ^ (s0 >> 2) ^ (s0 >> 7)
             ^ (dd << 63) ^ (dd << 62) ^ (dd << 57);
        return {s3 ^ h1, s2 ^ h0};
    endfunction

    // Track register writes, predict accepted blocks and check results.
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [127:0] operand;
        logic [127:0] product;
        logic [127:0] want;
        logic         bad;
        if (!rst_n)
        begin
            hash_key           = '0;
            swap_enable        = 1'b1;
            acc_model          = '0;
            pending_products.delete();
            products_in_flight <= 0;
            mismatch_count     <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KEY_HI:   hash_key[127:64] = cfg_data;
                    CFG_KEY_LO:   hash_key[63:0]   = cfg_data;
                    CFG_BYTE_REV: swap_enable      = cfg_data[0];
                    default: ;
                endcase
            end

            // One prediction per accepted block transaction.
            if (block_valid && !block_stall)
            begin
                case (kind)
                    KIND_ABSORB:
                    begin
                        operand = {block_hi, block_lo};
                        if (swap_enable)
                            operand = reverse_bytes(operand);
                        acc_model = gf128_mul(acc_model ^ operand, hash_key);
                        product   = acc_model;
                    end
                    KIND_RAW:
                        product = gf128_mul({block_hi, block_lo}, hash_key);
                    KIND_CLEAR:
                    begin
                        acc_model = '0;
                        product   = '0;
                    end
                    // The spare code reports the accumulator unchanged.
                    default:
                        product = acc_model;
                endcase
                pending_products.push_back(product);
            end

            // Compare each accepted result transaction field by field.
            if (result_valid && !result_stall)
            begin
                if (pending_products.size() == 0)
                begin
                    $display("%0t: unexpected result hi %h lo %h", $time,
                             result_hi, result_lo);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = pending_products.pop_front();
                    bad  = 1'b0;
                    if (result_hi !== want[127:64])
                    begin
                        $display("%0t: result_hi mismatch, expected %h, actual %h",
                                 $time, want[127:64], result_hi);
                        bad = 1'b1;
                    end
                    if (result_lo !== want[63:0])
                    begin
                        $display("%0t: result_lo mismatch, expected %h, actual %h",
                                 $time, want[63:0], result_lo);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count <= mismatch_count + 1;
                end
            end
            products_in_flight <= pending_products.size();
        end
    end

endmodule

// ===== tb/sv/ghash_gf128_multiply_accumulate_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_gf128_multiply_accumulate_test
// Drives the GHASH engine with a directed set of blocks and then with random
// GHASH messages and single operations under several hash keys and both byte
// orders. The sender works in bursts and the receiver stalls in changing
// patterns; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ghash_gf128_multiply_accumulate_test;
    import ghm_pkg::*;

    // The kind code that the package leaves without a meaning.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_style_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_HI;
    logic [63:0] cfg_data = '0;
    logic        block_valid = 1'b0;
    logic        block_stall;
    logic [1:0]  kind = KIND_ABSORB;
    logic [63:0] block_hi = '0;
    logic [63:0] block_lo = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [63:0] result_hi;
    logic [63:0] result_lo;

    int           products_in_flight;
    int           mismatch_count;
    int           burst_left;
    int           cycles;
    int           stall_timer;
    stall_style_t stall_mode;

    ghash_gf128_multiply_accumulate u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .block_valid  (block_valid),
        .block_stall  (block_stall),
        .kind         (kind),
        .block_hi     (block_hi),
        .block_lo     (block_lo),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_hi    (result_hi),
        .result_lo    (result_lo)
    );

    ghash_gf128_multiply_accumulate_check u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .block_valid        (block_valid),
        .block_stall        (block_stall),
        .kind               (kind),
        .block_hi           (block_hi),
        .block_lo           (block_lo),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .result_hi          (result_hi),
        .result_lo          (result_lo),
        .products_in_flight (products_in_flight),
        .mismatch_count     (mismatch_count)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stall pattern: the style changes whenever its timer runs out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode   <= STALL_NONE;
            stall_timer  <= 0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  <= stall_style_t'($urandom_range(0, 3));
                stall_timer <= $urandom_range(10, 80);
            end
            else
            begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                STALL_NONE:  result_stall <= 1'b0;
                STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if ($urandom_range(0, 11) == 0)
                        result_stall <= ~result_stall;
                end
            endcase
        end
    end

    // A lane value biased toward the extremes and single set bits.
    function automatic logic [63:0] rand_lane();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Any kind code, the spare one included.
    function automatic logic [1:0] rand_kind();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return KIND_ABSORB;
            4, 5, 6:    return KIND_RAW;
            7, 8:       return KIND_CLEAR;
            default:    return KIND_SPARE;
        endcase
    endfunction

    // Offer one block transaction, wait for it to be taken, then idle
    // between bursts.
    task automatic push_block(input logic [1:0] k, input logic [63:0] hi,
                              input logic [63:0] lo);
        int gap;
        block_valid <= 1'b1;
        kind        <= k;
        block_hi    <= hi;
        block_lo    <= lo;
        @(posedge clk);
        while (block_stall)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                               : $urandom_range(1, 3);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 7);
            block_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain();
        block_valid <= 1'b0;
        do
            @(posedge clk);
        while (products_in_flight != 0);
    endtask

    // Write the hash key and the byte reversal enable; block must be idle.
    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo,
                            input logic rev);
        cfg_write <= 1'b1;
        cfg_index <= CFG_KEY_HI;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_KEY_LO;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_BYTE_REV;
        cfg_data  <= {63'b0, rev};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin
        int          sent;
        int          n;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        rev;

        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: a zero key annihilates every product.
        push_block(KIND_ABSORB, '1, '1);
        push_block(KIND_RAW, '1, '1);
        push_block(KIND_SPARE, '0, '0);
        drain();

        // A typical key with byte reversal on.
        load_key(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1);
        push_block(KIND_ABSORB, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100);
        push_block(KIND_SPARE, '1, '1);
        push_block(KIND_ABSORB, '1, '1);
        push_block(KIND_ABSORB, '0, '0);
        push_block(KIND_ABSORB, 64'h8000000000000000, '0);
        push_block(KIND_ABSORB, '0, 64'd1);
        push_block(KIND_RAW, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100);
        push_block(KIND_RAW, '1, '1);
        push_block(KIND_RAW, '0, 64'd1);
        push_block(KIND_CLEAR, '1, '1);
        push_block(KIND_SPARE, '1, '1);
        push_block(KIND_ABSORB, 64'h8000000000000000, '0);
        drain();

        // All-ones key with byte reversal off.
        load_key('1, '1, 1'b0);
        push_block(KIND_ABSORB, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100);
        push_block(KIND_ABSORB, '1, '1);
        push_block(KIND_RAW, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100);
        push_block(KIND_SPARE, '0, '0);
        push_block(KIND_CLEAR, '0, '0);
        push_block(KIND_ABSORB, '0, '0);
        drain();

        // Random phases, each under its own key setting.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    key_hi = 64'h8000000000000000;
                    key_lo = '0;
                    rev    = 1'b0;
                end
                1:
                begin
                    key_hi = {$urandom, $urandom};
                    key_lo = {$urandom, $urandom};
                    rev    = 1'b1;
                end
                2:
                begin
                    key_hi = '0;
                    key_lo = 64'd1;
                    rev    = 1'b1;
                end
                default:
                begin
                    key_hi = rand_lane();
                    key_lo = {$urandom, $urandom};
                    rev    = 1'($urandom_range(0, 1));
                end
            endcase
            load_key(key_hi, key_lo, rev);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // A GHASH message: clear, a run of absorbs, maybe a read.
                    push_block(KIND_CLEAR, rand_lane(), rand_lane());
                    n = $urandom_range(1, 8);
                    repeat (n) push_block(KIND_ABSORB, rand_lane(), rand_lane());
                    sent += n + 1;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        push_block(KIND_SPARE, rand_lane(), rand_lane());
                        sent++;
                    end
                end
                else
                begin
                    push_block(rand_kind(), rand_lane(), rand_lane());
                    sent++;
                end
            end
            drain();
        end

        // Allow any stray result to show up before the verdict.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== ghash_gf128_multiply_accumulate.f =====
src/ghm_pkg.sv
src/ghm_clmul64.sv
src/ghm_gf_mul.sv
src/ghash_gf128_multiply_accumulate.sv
tb/sv/ghash_gf128_multiply_accumulate_check.sv
tb/sv/ghash_gf128_multiply_accumulate_test.sv
